// ===== rtl/brle_pkg.sv =====
// brle_pkg: shared types and constants of the RLE8 span decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package brle_pkg;

    localparam int REG_W   = 13;
    localparam int POS_W   = 14;
    localparam int ROW_W   = 12;
    localparam int CNT_W   = 8;
    localparam int SKIP_W  = 9;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;
    localparam int TDATA_W = 40;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [CNT_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [CNT_W-1:0] ESC_EOI   = 8'd1;
    localparam logic [CNT_W-1:0] ESC_DELTA = 8'd2;

    localparam logic KIND_SPAN = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] width;
        logic [POS_W-1:0] height;
    } brle_dim_t;

    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] mem_row;
        logic [ROW_W-1:0] column;
        logic [CNT_W-1:0] span_length;
        logic [CNT_W-1:0] pixel_value;
    } brle_span_t;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {{(POS_W+1-CNT_W){1'b0}}, b};
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/brle_cfg.sv =====
// brle_cfg: APB register file for image width and height.
// Depends on brle_pkg; clamps dim to the build-time maximum size.
`default_nettype none

module brle_cfg
    import brle_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready,
    output brle_dim_t              dim
);

    localparam logic [POS_W-1:0] MAX_W = POS_W'(MAX_WIDTH);
    localparam logic [POS_W-1:0] MAX_H = POS_W'(MAX_HEIGHT);

    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    logic             wr_en;
    logic             reg_sel;
    logic [POS_W-1:0] width_ext;
    logic [POS_W-1:0] height_ext;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ADDR_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= REG_W'(4096);
            height_reg <= REG_W'(4096);
        end else if (wr_en) begin
            if (reg_sel == REG_WIDTH) begin
                width_reg <= pwdata[REG_W-1:0];
            end else begin
                height_reg <= pwdata[REG_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_WIDTH) begin
            prdata = {{(APB_W-REG_W){1'b0}}, width_reg};
        end else begin
            prdata = {{(APB_W-REG_W){1'b0}}, height_reg};
        end
    end

    assign width_ext  = {{(POS_W-REG_W){1'b0}}, width_reg};
    assign height_ext = {{(POS_W-REG_W){1'b0}}, height_reg};
    assign dim.width  = (width_ext < MAX_W) ? width_ext : MAX_W;
    assign dim.height = (height_ext < MAX_H) ? height_ext : MAX_H;

endmodule

`default_nettype wire

// ===== rtl/brle_parser.sv =====
// brle_parser: RLE8 phase machine with position tracking and result register.
// Uses brle_pkg; takes one registered byte per cycle unless output stalls.
`default_nettype none

module brle_parser
    import brle_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic [CNT_W-1:0] in_byte,
    input  brle_dim_t             dim,
    output logic                  consume,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output brle_span_t            out_span
);

    typedef enum logic [3:0] {
        PH_CTRL, PH_RUNVAL, PH_ESC, PH_DX, PH_DY, PH_LIT, PH_PAD, PH_SKIP, PH_DONE
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  line_reg, line_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic              pad_reg, pad_next;
    logic              out_valid_reg, out_valid_next;
    brle_span_t        span_reg, span_next;

    logic              can_adv;
    logic [CNT_W-1:0]  fit_count;
    logic [POS_W:0]    col_end;
    logic              fits;
    logic [POS_W-1:0]  row_full;
    logic [CNT_W-1:0]  pend_dec;
    logic [SKIP_W-1:0] skip_dec;

    assign can_adv   = !out_valid_reg || out_ready;
    assign consume   = in_valid && can_adv;
    assign out_valid = out_valid_reg;
    assign out_span  = span_reg;

    assign fit_count = (phase_reg == PH_RUNVAL) ? pend_reg : in_byte;
    assign col_end   = {1'b0, col_reg} + {{(POS_W+1-CNT_W){1'b0}}, fit_count};
    assign fits      = (col_end <= {1'b0, dim.width}) && (line_reg < dim.height);
    assign row_full  = dim.height - POS_W'(1) - line_reg;
    assign pend_dec  = pend_reg - CNT_W'(1);
    assign skip_dec  = (skip_reg != '0) ? skip_reg - SKIP_W'(1) : skip_reg;

    always_comb begin
        phase_next     = phase_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        pend_next      = pend_reg;
        skip_next      = skip_reg;
        pad_next       = pad_reg;
        out_valid_next = 1'b0;
        span_next      = '0;
        span_next.mem_row = row_full[ROW_W-1:0];
        span_next.column  = col_reg[ROW_W-1:0];
        span_next.kind    = KIND_SPAN;
        case (phase_reg)
            PH_CTRL: begin
                if (in_byte != '0) begin
                    pend_next  = in_byte;
                    phase_next = PH_RUNVAL;
                end else begin
                    phase_next = PH_ESC;
                end
            end
            PH_RUNVAL: begin
                phase_next = PH_CTRL;
                if (fits) begin
                    out_valid_next        = 1'b1;
                    span_next.span_length = pend_reg;
                    span_next.pixel_value = in_byte;
                    col_next              = sat_add(col_reg, pend_reg);
                end
            end
            PH_ESC: begin
                case (in_byte)
                    ESC_EOL: begin
                        col_next   = '0;
                        line_next  = sat_add(line_reg, CNT_W'(1));
                        phase_next = PH_CTRL;
                    end
                    ESC_EOI: begin
                        phase_next     = PH_DONE;
                        out_valid_next = 1'b1;
                        span_next      = '0;
                        span_next.kind = KIND_END;
                    end
                    ESC_DELTA: begin
                        phase_next = PH_DX;
                    end
                    default: begin
                        if (fits) begin
                            pend_next  = in_byte;
                            pad_next   = in_byte[0];
                            phase_next = PH_LIT;
                        end else begin
                            skip_next  = {1'b0, in_byte} + {{(SKIP_W-1){1'b0}}, in_byte[0]};
                            phase_next = PH_SKIP;
                        end
                    end
                endcase
            end
            PH_DX: begin
                pend_next  = in_byte;
                phase_next = PH_DY;
            end
            PH_DY: begin
                col_next   = sat_add(col_reg, pend_reg);
                line_next  = sat_add(line_reg, in_byte);
                pend_next  = '0;
                phase_next = PH_CTRL;
            end
            PH_LIT: begin
                out_valid_next        = 1'b1;
                span_next.span_length = CNT_W'(1);
                span_next.pixel_value = in_byte;
                col_next              = sat_add(col_reg, CNT_W'(1));
                pend_next             = pend_dec;
                if (pend_dec == '0) begin
                    phase_next = pad_reg ? PH_PAD : PH_CTRL;
                end
            end
            PH_PAD: begin
                pad_next   = 1'b0;
                phase_next = PH_CTRL;
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = PH_CTRL;
                end
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = PH_CTRL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CTRL;
            col_reg       <= '0;
            line_reg      <= '0;
            pend_reg      <= '0;
            skip_reg      <= '0;
            pad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (consume) begin
            phase_reg     <= phase_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            pend_reg      <= pend_next;
            skip_reg      <= skip_next;
            pad_reg       <= pad_next;
            out_valid_reg <= out_valid_next;
            if (out_valid_next) begin
                span_reg <= span_next;
            end
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bmp_rle8_span_decoder.sv =====
// Top level of the RLE8 span decoder: input register, parser and APB registers.
// Depends on brle_pkg, brle_cfg and brle_parser.
//
// Decodes a bitmap RLE8 byte stream into pixel spans. Sustains one
// compressed byte per clock while the master side does not stall: a byte
// enters the input register on acceptance and its span, if any, is then
// loaded from the input register into the result register, which drives
// m_tvalid. A stalled master side holds both registers and drops s_tready.
// Each span gives memory row, start column, length and palette index; an
// end-of-image escape yields one request with m_tuser high and all data
// zero, after which bytes are swallowed until reset. Runs or literal groups
// that would cross the image edge are consumed without output. Write
// image_width (address 0) and image_height (address 4) only while the
// decoder is idle; both are clamped to MAX_WIDTH and MAX_HEIGHT.
`default_nettype none

module bmp_rle8_span_decoder
    import brle_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [CNT_W-1:0]    s_tdata,   // data_byte
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,   // pixel_value, span_length, column, mem_row (MSB first)
    output logic                     m_tuser,   // kind
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [APB_W-1:0]    pwdata,
    output logic      [APB_W-1:0]    prdata,
    output logic                     pready
);

    logic             in_valid_reg;
    logic [CNT_W-1:0] in_byte_reg;
    logic             consume;
    brle_dim_t        dim;
    brle_span_t       span;

    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    brle_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dim     (dim)
    );

    brle_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .dim       (dim),
        .consume   (consume),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_span  (span)
    );

    assign m_tuser = span.kind;
    assign m_tdata = {span.pixel_value, span.span_length, span.column, span.mem_row};

endmodule

`default_nettype wire

// ===== rtl/brle_checker.sv =====
// brle_checker: port-level assertions for the RLE8 span decoder.
// Depends on brle_pkg; bound to bmp_rle8_span_decoder below.
`default_nettype none

module brle_checker
    import brle_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tuser
);

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("request or stall left after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled request dropped or changed");

    a_end_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=> !m_tvalid)
        else $error("request after end of image");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("end of image request carries data");

    a_span_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[TDATA_W-CNT_W-1:TDATA_W-2*CNT_W] != '0)
        else $error("span of zero length");

endmodule

bind bmp_rle8_span_decoder brle_checker u_brle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
